[sv/video_chip_cpu_register_port_core_macros.svh]
// Assertion macros shared by the video chip register port RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef VIDEO_CHIP_CPU_REGISTER_PORT_CORE_MACROS_SVH
`define VIDEO_CHIP_CPU_REGISTER_PORT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VCRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VCRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vcrp_pkg.sv]
// Types and constants of the video chip CPU register port.
// No dependencies; used by the interfaces and the core module.
package vcrp_pkg;

  // Field widths of the request and result items
  localparam int REG_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int VADDR_W = 16;
  localparam int TADDR_W = 15;
  localparam int FINE_W  = 3;

  // Request type codes
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Register index codes
  localparam logic [REG_W-1:0] REG_CTRL      = 3'd0;
  localparam logic [REG_W-1:0] REG_MASK      = 3'd1;
  localparam logic [REG_W-1:0] REG_STATUS    = 3'd2;
  localparam logic [REG_W-1:0] REG_OAM_ADDR  = 3'd3;
  localparam logic [REG_W-1:0] REG_OAM_DATA  = 3'd4;
  localparam logic [REG_W-1:0] REG_SCROLL    = 3'd5;
  localparam logic [REG_W-1:0] REG_ADDR      = 3'd6;
  localparam logic [REG_W-1:0] REG_VRAM_DATA = 3'd7;

  // Result source codes for the second stage
  localparam int SRC_W = 2;
  localparam logic [SRC_W-1:0] SRC_FIXED  = 2'd0;
  localparam logic [SRC_W-1:0] SRC_STATUS = 2'd1;
  localparam logic [SRC_W-1:0] SRC_OAM    = 2'd2;
  localparam logic [SRC_W-1:0] SRC_DATA   = 2'd3;

  // Constants of the register behavior
  localparam logic [BYTE_W-1:0]  STATUS_KEEP    = 8'hE0;
  localparam logic [BYTE_W-1:0]  BUF_LOW        = 8'h1F;
  localparam logic [BYTE_W-1:0]  NMI_CLEAR      = 8'h7F;
  localparam logic [VADDR_W-1:0] PALETTE_BASE   = 16'h3F00;
  localparam logic [VADDR_W-1:0] PALETTE_MIRROR = 16'h1F00;
  localparam logic [VADDR_W-1:0] STEP_WIDE      = 16'd32;
  localparam logic [VADDR_W-1:0] STEP_NARROW    = 16'd1;

endpackage

[sv/vcrp_req_if.sv]
// Request channel: one CPU register read or write per item.
// Depends on vcrp_pkg for field widths.
interface vcrp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [vcrp_pkg::REG_W-1:0]  reg_index;
  logic [vcrp_pkg::BYTE_W-1:0] write_byte;

  modport source(output valid, req_type, reg_index, write_byte, input ready);
  modport sink(input valid, req_type, reg_index, write_byte, output ready);
endinterface

[sv/vcrp_rsp_if.sv]
// Result channel: read byte and register snapshot after each item.
// Depends on vcrp_pkg for field widths.
interface vcrp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [vcrp_pkg::BYTE_W-1:0]  read_byte;
  logic [vcrp_pkg::VADDR_W-1:0] current_vram_address;
  logic [vcrp_pkg::TADDR_W-1:0] temporary_address;
  logic [vcrp_pkg::FINE_W-1:0]  fine_scroll_x;
  logic [vcrp_pkg::BYTE_W-1:0]  control_value;
  logic [vcrp_pkg::BYTE_W-1:0]  mask_value;

  modport source(output valid, read_byte, current_vram_address, temporary_address,
                 fine_scroll_x, control_value, mask_value, input ready);
  modport sink(input valid, read_byte, current_vram_address, temporary_address,
               fine_scroll_x, control_value, mask_value, output ready);
endinterface

[sv/vcrp_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module vcrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read old contents when enabled; hold read data otherwise
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[sv/video_chip_cpu_register_port_core.sv]
// CPU register port of a video chip: eight registers, sprite RAM, video RAM.
// Each item passes the second stage and output registers; memory reads issue at accept.
// Throughput: one item per cycle unless rsp stalls; memory data returns next cycle.
// Reset: synchronous; clears the architectural registers and stage valids, then a clearing
// pass zeroes video and sprite RAM while req.ready stays low.
// Depends on vcrp_pkg, vcrp_req_if, vcrp_rsp_if, vcrp_ram and the macros header.
`include "video_chip_cpu_register_port_core_macros.svh"

module video_chip_cpu_register_port_core #(
  parameter int SPRITE_BYTES = 256,
  parameter int VIDEO_BYTES  = 16384
) (
  input  logic         clk,
  input  logic         rst,
  vcrp_req_if.sink     req,
  vcrp_rsp_if.source   rsp
);

  localparam int SA_W = $clog2(SPRITE_BYTES);
  localparam int VA_W = $clog2(VIDEO_BYTES);
  localparam int BW   = vcrp_pkg::BYTE_W;
  localparam int AW   = vcrp_pkg::VADDR_W;
  localparam int TW   = vcrp_pkg::TADDR_W;
  localparam int FW   = vcrp_pkg::FINE_W;

  // Architectural registers
  logic [BW-1:0]   control_reg, mask_reg, status_reg, open_bus_byte, read_buffer;
  logic [SA_W-1:0] sprite_addr;
  logic            second_write;
  logic [TW-1:0]   temp_addr_reg;
  logic [AW-1:0]   vram_addr_reg;
  logic [FW-1:0]   fine_x_reg;

  // Next values at accept
  logic [BW-1:0]   control_next, mask_next, status_next, open_bus_next;
  logic [SA_W-1:0] sprite_addr_next;
  logic            second_write_next;
  logic [TW-1:0]   temp_addr_next;
  logic [AW-1:0]   vram_addr_next;
  logic [FW-1:0]   fine_x_next;

  // Clearing pass
  logic [VA_W:0]   clr_cnt;
  logic            clearing;

  // Second stage
  logic                      s1_valid;
  logic [vcrp_pkg::SRC_W-1:0] s1_src, src_next;
  logic [BW-1:0]             s1_byte, byte_next;
  logic                      s1_palette, palette_next;
  logic [AW-1:0]             s1_vaddr;
  logic [TW-1:0]             s1_taddr;
  logic [FW-1:0]             s1_fine;
  logic [BW-1:0]             s1_ctrl, s1_mask;
  logic                      s1_go;
  logic [BW-1:0]             result_byte;

  // Output register
  logic            out_valid;
  logic [BW-1:0]   out_byte, out_ctrl, out_mask;
  logic [AW-1:0]   out_vaddr;
  logic [TW-1:0]   out_taddr;
  logic [FW-1:0]   out_fine;

  // Memory ports
  logic            accept;
  logic [VA_W-1:0] vaddr_low, vram_raddr_b;
  logic            vram_we, oam_we;
  logic [VA_W-1:0] vram_waddr;
  logic [SA_W-1:0] oam_waddr;
  logic [BW-1:0]   vram_wdata, oam_wdata;
  logic [BW-1:0]   vram_rdata_a, vram_rdata_b, oam_rdata;
  logic [AW-1:0]   step;

  assign clearing = !clr_cnt[VA_W];
  assign s1_go    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !clearing && (!s1_valid || s1_go);
  assign accept   = req.valid && req.ready;

  assign vaddr_low    = vram_addr_reg[VA_W-1:0];
  assign vram_raddr_b = vaddr_low - vcrp_pkg::PALETTE_MIRROR[VA_W-1:0];
  assign step         = control_reg[2] ? vcrp_pkg::STEP_WIDE : vcrp_pkg::STEP_NARROW;

  // Decode one item: register updates and what the second stage returns
  always_comb begin
    control_next      = control_reg;
    mask_next         = mask_reg;
    status_next       = status_reg;
    open_bus_next     = open_bus_byte;
    sprite_addr_next  = sprite_addr;
    second_write_next = second_write;
    temp_addr_next    = temp_addr_reg;
    vram_addr_next    = vram_addr_reg;
    fine_x_next       = fine_x_reg;
    src_next          = vcrp_pkg::SRC_FIXED;
    byte_next         = '0;
    palette_next      = 1'b0;
    if (req.req_type == vcrp_pkg::REQ_WRITE) begin
      open_bus_next = req.write_byte;
      case (req.reg_index)
        vcrp_pkg::REG_CTRL: begin
          control_next          = req.write_byte;
          temp_addr_next[11:10] = req.write_byte[1:0];
        end
        vcrp_pkg::REG_MASK:     mask_next = req.write_byte;
        vcrp_pkg::REG_STATUS:   status_next = req.write_byte;
        vcrp_pkg::REG_OAM_ADDR: sprite_addr_next = req.write_byte[SA_W-1:0];
        vcrp_pkg::REG_OAM_DATA: sprite_addr_next = sprite_addr + 1'b1;
        vcrp_pkg::REG_SCROLL: begin
          if (!second_write) begin
            fine_x_next         = req.write_byte[2:0];
            temp_addr_next[4:0] = req.write_byte[7:3];
          end else begin
            temp_addr_next[9:5]   = req.write_byte[7:3];
            temp_addr_next[14:12] = req.write_byte[2:0];
          end
          second_write_next = !second_write;
        end
        vcrp_pkg::REG_ADDR: begin
          if (!second_write) begin
            temp_addr_next = {1'b0, req.write_byte[5:0], 8'h00};
          end else begin
            temp_addr_next = {temp_addr_reg[TW-1:8], req.write_byte};
            vram_addr_next = {1'b0, temp_addr_next};
          end
          second_write_next = !second_write;
        end
        default: vram_addr_next = vram_addr_reg + step;
      endcase
    end else begin
      case (req.reg_index)
        vcrp_pkg::REG_STATUS: begin
          src_next          = vcrp_pkg::SRC_STATUS;
          byte_next         = status_reg & vcrp_pkg::STATUS_KEEP;
          status_next       = status_reg & vcrp_pkg::NMI_CLEAR;
          second_write_next = 1'b0;
        end
        vcrp_pkg::REG_OAM_DATA: src_next = vcrp_pkg::SRC_OAM;
        vcrp_pkg::REG_VRAM_DATA: begin
          src_next       = vcrp_pkg::SRC_DATA;
          palette_next   = vaddr_low >= vcrp_pkg::PALETTE_BASE[VA_W-1:0];
          vram_addr_next = vram_addr_reg + step;
        end
        default: byte_next = open_bus_byte;
      endcase
    end
  end

  // Memory write ports: clearing pass first, then data and sprite writes
  always_comb begin
    vram_we    = accept && req.req_type == vcrp_pkg::REQ_WRITE &&
                 req.reg_index == vcrp_pkg::REG_VRAM_DATA;
    vram_waddr = vaddr_low;
    vram_wdata = req.write_byte;
    oam_we     = accept && req.req_type == vcrp_pkg::REQ_WRITE &&
                 req.reg_index == vcrp_pkg::REG_OAM_DATA;
    oam_waddr  = sprite_addr;
    oam_wdata  = req.write_byte;
    if (clearing) begin
      vram_we    = 1'b1;
      vram_waddr = clr_cnt[VA_W-1:0];
      vram_wdata = '0;
      oam_we     = 1'b1;
      oam_waddr  = clr_cnt[SA_W-1:0];
      oam_wdata  = '0;
    end
  end

  vcrp_ram #(.WIDTH(BW), .DEPTH(VIDEO_BYTES)) u_vram (
    .clk     (clk),
    .we      (vram_we),
    .waddr   (vram_waddr),
    .wdata   (vram_wdata),
    .re      (accept),
    .raddr_a (vaddr_low),
    .raddr_b (vram_raddr_b),
    .rdata_a (vram_rdata_a),
    .rdata_b (vram_rdata_b)
  );

  vcrp_ram #(.WIDTH(BW), .DEPTH(SPRITE_BYTES)) u_oam (
    .clk     (clk),
    .we      (oam_we),
    .waddr   (oam_waddr),
    .wdata   (oam_wdata),
    .re      (accept),
    .raddr_a (sprite_addr),
    .raddr_b (sprite_addr),
    .rdata_a (oam_rdata),
    .rdata_b ()
  );

  // Pick the returned byte once memory data is back
  always_comb begin
    case (s1_src)
      vcrp_pkg::SRC_STATUS: result_byte = s1_byte | (read_buffer & vcrp_pkg::BUF_LOW);
      vcrp_pkg::SRC_OAM:    result_byte = oam_rdata;
      vcrp_pkg::SRC_DATA:   result_byte = s1_palette ? vram_rdata_a : read_buffer;
      default:              result_byte = s1_byte;
    endcase
  end

  // Control: clearing pass, register updates, stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      control_reg   <= '0;
      mask_reg      <= '0;
      status_reg    <= '0;
      open_bus_byte <= '0;
      read_buffer   <= '0;
      sprite_addr   <= '0;
      second_write  <= 1'b0;
      temp_addr_reg <= '0;
      vram_addr_reg <= '0;
      fine_x_reg    <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept) begin
        control_reg   <= control_next;
        mask_reg      <= mask_next;
        status_reg    <= status_next;
        open_bus_byte <= open_bus_next;
        sprite_addr   <= sprite_addr_next;
        second_write  <= second_write_next;
        temp_addr_reg <= temp_addr_next;
        vram_addr_reg <= vram_addr_next;
        fine_x_reg    <= fine_x_next;
      end
      // Load the read buffer in item order, as each data read retires
      if (s1_go && s1_src == vcrp_pkg::SRC_DATA) begin
        read_buffer <= s1_palette ? vram_rdata_b : vram_rdata_a;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: snapshot at accept, result at retire
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src     <= src_next;
      s1_byte    <= byte_next;
      s1_palette <= palette_next;
      s1_vaddr   <= vram_addr_next;
      s1_taddr   <= temp_addr_next;
      s1_fine    <= fine_x_next;
      s1_ctrl    <= control_next;
      s1_mask    <= mask_next;
    end
    if (s1_go) begin
      out_byte  <= result_byte;
      out_vaddr <= s1_vaddr;
      out_taddr <= s1_taddr;
      out_fine  <= s1_fine;
      out_ctrl  <= s1_ctrl;
      out_mask  <= s1_mask;
    end
  end

  assign rsp.valid                = out_valid;
  assign rsp.read_byte            = out_byte;
  assign rsp.current_vram_address = out_vaddr;
  assign rsp.temporary_address    = out_taddr;
  assign rsp.fine_scroll_x        = out_fine;
  assign rsp.control_value        = out_ctrl;
  assign rsp.mask_value           = out_mask;

  // Checks
  `VCRP_ASSERT_IMP(a_no_accept_clearing, clk, rst, clearing, !req.ready, "item taken during clearing pass")
  `VCRP_ASSERT_IMP(a_stall_blocks_input, clk, rst, s1_valid && out_valid && !rsp.ready, !req.ready, "input taken while pipeline stalled")
  `VCRP_ASSERT_NEXT(a_status_read_clears, clk, rst, accept && req.req_type == vcrp_pkg::REQ_READ && req.reg_index == vcrp_pkg::REG_STATUS, !second_write && !status_reg[7], "status read left toggle or NMI set")
  `VCRP_ASSERT_NEXT(a_data_steps_addr, clk, rst, accept && req.reg_index == vcrp_pkg::REG_VRAM_DATA, vram_addr_reg == $past(vram_addr_reg + step), "data access did not step address")

endmodule
